/* src/sfrc_pkg.sv */
// Shared types and constants for the sync-framed receiver with checksum.
package sfrc_pkg;

  localparam logic [7:0] SyncByte   = 8'hFF;
  localparam int unsigned PayloadLen = 8;
  localparam int unsigned HeadLen    = 3;
  localparam int unsigned IdxW       = $clog2(PayloadLen);
  localparam int unsigned AccW       = 12;  // holds -764 .. 1276
  localparam int unsigned MagW       = 11;  // |acc| up to 1276

  // Frame phase, one-hot.
  typedef enum logic [4:0] {
    PH_HUNT0   = 5'b00001,
    PH_HUNT1   = 5'b00010,
    PH_PAYLOAD = 5'b00100,
    PH_CHK_HI  = 5'b01000,
    PH_CHK_LO  = 5'b10000
  } phase_e;

  typedef logic [PayloadLen-1:0][7:0] payload_t;

  // Framer to top: a good frame ended on this transaction.
  typedef struct packed {
    logic     hit;
    payload_t payload;
  } frame_out_t;

endpackage

/* src/sfrc_framer.sv */
// Sync hunt, payload capture and running checksum for one byte per cycle while accept_i is high.
module sfrc_framer (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  logic [7:0]              rx_byte_i,
  output sfrc_pkg::frame_out_t    frame_o
);

  sfrc_pkg::phase_e                      phase_q, phase_d;
  logic [sfrc_pkg::IdxW-1:0]             idx_q, idx_d;
  logic signed [sfrc_pkg::AccW-1:0]      acc_q, acc_d;
  logic [7:0]                            chk_hi_q, chk_hi_d;
  sfrc_pkg::payload_t                    store_q, store_d;
  logic [sfrc_pkg::MagW-1:0]             mag;
  logic signed [sfrc_pkg::AccW-1:0]      byte_ext;
  logic                                  is_sync;

  assign byte_ext = $signed({{(sfrc_pkg::AccW-8){1'b0}}, rx_byte_i});
  assign is_sync  = (rx_byte_i == sfrc_pkg::SyncByte);
  assign mag      = acc_q[sfrc_pkg::AccW-1] ? sfrc_pkg::MagW'(-acc_q)
                                            : acc_q[sfrc_pkg::MagW-1:0];

  always_comb begin
    phase_d  = phase_q;
    idx_d    = idx_q;
    acc_d    = acc_q;
    chk_hi_d = chk_hi_q;
    store_d  = store_q;
    if (accept_i) begin
      case (phase_q)
        sfrc_pkg::PH_HUNT1: begin
          if (is_sync) begin
            phase_d = sfrc_pkg::PH_PAYLOAD;
            idx_d   = '0;
            acc_d   = sfrc_pkg::AccW'(1);
          end else begin
            phase_d = sfrc_pkg::PH_HUNT0;
          end
        end
        sfrc_pkg::PH_PAYLOAD: begin
          store_d[idx_q] = rx_byte_i;
          // head bytes subtract, the rest add
          if (idx_q < sfrc_pkg::IdxW'(sfrc_pkg::HeadLen)) acc_d = acc_q - byte_ext;
          else                                              acc_d = acc_q + byte_ext;
          idx_d = idx_q + 1'b1;
          if (idx_q == sfrc_pkg::IdxW'(sfrc_pkg::PayloadLen - 1)) begin
            phase_d = sfrc_pkg::PH_CHK_HI;
          end
        end
        sfrc_pkg::PH_CHK_HI: begin
          chk_hi_d = rx_byte_i;
          phase_d  = sfrc_pkg::PH_CHK_LO;
        end
        sfrc_pkg::PH_CHK_LO: begin
          phase_d = sfrc_pkg::PH_HUNT0;
        end
        default: begin  // hunting first sync byte
          phase_d = is_sync ? sfrc_pkg::PH_HUNT1 : sfrc_pkg::PH_HUNT0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sfrc_pkg::PH_HUNT0;
      idx_q   <= '0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    chk_hi_q <= chk_hi_d;
    store_q  <= store_d;
  end

  assign frame_o.hit = accept_i && (phase_q == sfrc_pkg::PH_CHK_LO) &&
                       ({chk_hi_q, rx_byte_i} == {{(16-sfrc_pkg::MagW){1'b0}}, mag});
  assign frame_o.payload = store_q;

  // Index wraps to zero exactly when capture ends.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == sfrc_pkg::PH_CHK_HI) |-> (idx_q == '0))
    else $error("payload index not wrapped at check byte");

  // Capture always starts from the +1 seed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && phase_q == sfrc_pkg::PH_HUNT1 && is_sync) |=>
      (phase_q == sfrc_pkg::PH_PAYLOAD && idx_q == '0 && acc_q == 1))
    else $error("checksum seed not loaded after sync");

  // Phase register stays one-hot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(phase_q))
    else $error("frame phase not one-hot");

endmodule

/* src/sync_frame_receiver_checksum.sv */
// Top level: sync-framed byte receiver with additive checksum check.
//
// Takes one received byte per transaction and can take a byte every cycle.
// It hunts for two 0xFF sync bytes, captures three head bytes, the angle byte,
// two X and two Y bytes, then the check high and low bytes. A running signed
// sum (X, Y and angle added, head bytes subtracted, seeded with +1) is kept as
// bytes arrive, so on the check low byte only an absolute value and a 16-bit
// compare remain. A match produces one result transaction with the eight
// payload bytes in the cycle after the last byte; a mismatch drops the frame and
// the block goes back to hunting. A third 0xFF in a row is taken as head byte 0.
// The result sits in an output register; new bytes keep flowing in while it waits,
// and input stalls only when a result is held and out_ready_i is low.
module sync_frame_receiver_checksum (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] head_byte_0_o,
  output logic [7:0] head_byte_1_o,
  output logic [7:0] head_byte_2_o,
  output logic [7:0] angle_byte_o,
  output logic [7:0] x_first_o,
  output logic [7:0] x_second_o,
  output logic [7:0] y_first_o,
  output logic [7:0] y_second_o
);

  logic                 in_accept;
  sfrc_pkg::frame_out_t frame;
  logic                 out_valid_q, out_valid_d;
  sfrc_pkg::payload_t   res_q, res_d;

  // Stall input only while a result is held and not taken.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_accept  = in_valid_i && in_ready_o;

  sfrc_framer u_framer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (in_accept),
    .rx_byte_i (rx_byte_i),
    .frame_o   (frame)
  );

  // Output register: load on a good frame, clear when taken.
  always_comb begin
    out_valid_d = out_valid_q;
    res_d       = res_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (frame.hit) begin
      out_valid_d = 1'b1;
      res_d       = frame.payload;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o   = out_valid_q;
  assign head_byte_0_o = res_q[0];
  assign head_byte_1_o = res_q[1];
  assign head_byte_2_o = res_q[2];
  assign angle_byte_o  = res_q[3];
  assign x_first_o     = res_q[4];
  assign x_second_o    = res_q[5];
  assign y_first_o     = res_q[6];
  assign y_second_o    = res_q[7];

  // A held result is never overwritten by a new frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !frame.hit)
    else $error("result overwritten while stalled");

  // A good frame always shows up at the output next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame.hit |=> (out_valid_o && res_q == $past(frame.payload)))
    else $error("good frame not presented");

  // A stalled result stays up with its payload unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(res_q)))
    else $error("result dropped or changed while stalled");

endmodule

/* tb/tb_sync_frame_receiver_checksum.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the sync-framed byte receiver with checksum check.
module tb_sync_frame_receiver_checksum;

  localparam int unsigned ClkHalf     = 5;
  localparam int unsigned RandBytes   = 1400;   // framed bytes in the random part
  localparam int unsigned HoldCycles  = 300;    // long receiver hold-off
  localparam int unsigned DrainCycles = 8;      // result shows in the cycle after its byte
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned MaxReports  = 10;

  logic       clk;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic [7:0] rx_byte   = 8'h00;
  logic       out_ready = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] head_byte_0_o, head_byte_1_o, head_byte_2_o, angle_byte_o;
  logic [7:0] x_first_o, x_second_o, y_first_o, y_second_o;

  sync_frame_receiver_checksum uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready_o),
    .rx_byte_i     (rx_byte),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready),
    .head_byte_0_o (head_byte_0_o),
    .head_byte_1_o (head_byte_1_o),
    .head_byte_2_o (head_byte_2_o),
    .angle_byte_o  (angle_byte_o),
    .x_first_o     (x_first_o),
    .x_second_o    (x_second_o),
    .y_first_o     (y_first_o),
    .y_second_o    (y_second_o)
  );

  // Traffic shaping, shared between the test tasks and the driver processes.
  bit no_gaps  = 1'b0;   // sender offers back to back
  bit no_stall = 1'b0;   // receiver always ready
  bit hold_req = 1'b0;   // ask the receiver for one long hold-off

  int unsigned cycles     = 0;
  int unsigned mismatches = 0;

  // Frame tracker: mirrors the block's framing state byte by byte.
  sfrc_pkg::phase_e          rx_phase;
  logic [sfrc_pkg::IdxW-1:0] pay_idx;
  sfrc_pkg::payload_t        rx_payload;
  logic [7:0]                chk_hi;
  sfrc_pkg::payload_t        good_frame_q [$];   // payloads of frames that passed the check

  string field_name [sfrc_pkg::PayloadLen] = '{"head_byte_0", "head_byte_1", "head_byte_2",
                                               "angle_byte", "x_first", "x_second",
                                               "y_first", "y_second"};

  initial begin
    clk = 1'b0;
    forever #ClkHalf clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

  // |(angle + X + Y) - heads + 1|, always fits in 16 bits without wrapping
  function automatic logic [15:0] frame_checksum(input sfrc_pkg::payload_t p);
    int plus;
    int minus;
    plus  = int'(p[3]) + int'(p[4]) + int'(p[5]) + int'(p[6]) + int'(p[7]) + 1;
    minus = int'(p[0]) + int'(p[1]) + int'(p[2]);
    return (plus >= minus) ? 16'(plus - minus) : 16'(minus - plus);
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 88) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  // Random byte, biased toward the extremes so sync and zero values show up often.
  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    else if (r == 1) return sfrc_pkg::SyncByte;
    else return 8'($urandom_range(0, 255));
  endfunction

  // Advance the tracker by one accepted byte; a good check queues the payload.
  task automatic track_rx_byte(input logic [7:0] b);
    case (rx_phase)
      sfrc_pkg::PH_HUNT0: begin
        if (b == sfrc_pkg::SyncByte) rx_phase = sfrc_pkg::PH_HUNT1;
      end
      sfrc_pkg::PH_HUNT1: begin
        if (b == sfrc_pkg::SyncByte) begin
          rx_phase = sfrc_pkg::PH_PAYLOAD;
          pay_idx  = '0;
        end else begin
          rx_phase = sfrc_pkg::PH_HUNT0;
        end
      end
      sfrc_pkg::PH_PAYLOAD: begin
        // a third sync in a row lands here as head byte 0
        rx_payload[pay_idx] = b;
        if (pay_idx == sfrc_pkg::IdxW'(sfrc_pkg::PayloadLen - 1)) begin
          rx_phase = sfrc_pkg::PH_CHK_HI;
        end
        pay_idx = pay_idx + 1'b1;
      end
      sfrc_pkg::PH_CHK_HI: begin
        chk_hi   = b;
        rx_phase = sfrc_pkg::PH_CHK_LO;
      end
      sfrc_pkg::PH_CHK_LO: begin
        // bad frames vanish without a result; either way back to hunting
        if ({chk_hi, b} == frame_checksum(rx_payload)) good_frame_q.push_back(rx_payload);
        rx_phase = sfrc_pkg::PH_HUNT0;
      end
      default: begin
        rx_phase = sfrc_pkg::PH_HUNT0;
      end
    endcase
  endtask

  // One input transaction. Called when clk has just risen; valid stays up
  // between back-to-back bytes.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready_o);
    track_rx_byte(b);
  endtask

  task automatic send_frame(input sfrc_pkg::payload_t p, input logic [15:0] chk);
    int k;
    send_byte(sfrc_pkg::SyncByte);
    send_byte(sfrc_pkg::SyncByte);
    for (k = 0; k < sfrc_pkg::PayloadLen; k++) send_byte(p[k]);
    send_byte(chk[15:8]);
    send_byte(chk[7:0]);
  endtask

  task automatic send_good_frame(input sfrc_pkg::payload_t p);
    send_frame(p, frame_checksum(p));
  endtask

  // Receiver side: random ready, always ready in no-stall mode, or one long hold-off on request.
  initial begin
    int unsigned gap;
    int unsigned n;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        for (n = 0; n < HoldCycles; n++) @(posedge clk);
        hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if (no_stall) begin
        out_ready <= 1'b1;
      end else begin
        gap = pick_gap();
        if (gap == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          repeat (gap - 1) @(posedge clk);
        end
      end
    end
  end

  // Compare one result transaction against the oldest good frame.
  task automatic check_result();
    sfrc_pkg::payload_t got;
    sfrc_pkg::payload_t want;
    bit                 bad;
    int                 k;
    got = {y_second_o, y_first_o, x_second_o, x_first_o,
           angle_byte_o, head_byte_2_o, head_byte_1_o, head_byte_0_o};
    if (good_frame_q.size() == 0) begin
      if (mismatches < MaxReports) $display("unexpected result transaction: %h", got);
      mismatches++;
    end else begin
      want = good_frame_q.pop_front();
      bad  = 1'b0;
      for (k = 0; k < sfrc_pkg::PayloadLen; k++) begin
        if (got[k] !== want[k]) begin
          bad = 1'b1;
          if (mismatches < MaxReports) begin
            $display("%s: expected %h, got %h", field_name[k], want[k], got[k]);
          end
        end
      end
      if (bad) mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid_o && out_ready) check_result();
  end

  // Noise while hunting, a lone sync byte, then a clean frame.
  task automatic test_sync_hunt();
    sfrc_pkg::payload_t p;
    send_byte(8'h00);
    send_byte(8'hFE);
    send_byte(sfrc_pkg::SyncByte);
    send_byte(8'h7F);
    p = {8'h80, 8'h01, 8'hC3, 8'h3C, 8'h55, 8'hAA, 8'h0F, 8'hF0};
    send_good_frame(p);
  endtask

  // Largest and smallest sum, all-zero frame, and zero sum.
  // The all-heads-0xFF frame also puts a third sync byte in head byte 0.
  task automatic test_sum_extremes();
    sfrc_pkg::payload_t p;
    int                 k;
    for (k = 0; k < sfrc_pkg::PayloadLen; k++) p[k] = (k < sfrc_pkg::HeadLen) ? 8'h00 : 8'hFF;
    send_good_frame(p);
    for (k = 0; k < sfrc_pkg::PayloadLen; k++) p[k] = (k < sfrc_pkg::HeadLen) ? 8'hFF : 8'h00;
    send_good_frame(p);
    p = '0;
    send_good_frame(p);
    p[0] = 8'h01;   // sum lands exactly on zero
    send_good_frame(p);
  endtask

  // Wrong high byte, wrong low byte, then the block must resync on a good frame.
  task automatic test_bad_checksum();
    sfrc_pkg::payload_t p;
    logic [15:0]        c;
    int                 k;
    for (k = 0; k < sfrc_pkg::PayloadLen; k++) p[k] = pick_byte();
    c = frame_checksum(p);
    send_frame(p, c ^ 16'h0100);
    send_frame(p, c ^ 16'h0001);
    send_good_frame(p);
  endtask

  // Receiver holds off while the sender streams good frames back to back,
  // so the output register fills and the input has to stall.
  task automatic test_output_backpressure();
    sfrc_pkg::payload_t p;
    int                 k;
    hold_req = 1'b1;
    no_gaps  = 1'b1;
    repeat (5) begin
      for (k = 0; k < sfrc_pkg::PayloadLen; k++) p[k] = pick_byte();
      send_good_frame(p);
    end
    no_gaps = 1'b0;
  endtask

  // Mostly good frames with random content; the rest corrupted checks,
  // truncated frames and loose noise. Idle modes change every 16 frames or noise bursts.
  task automatic test_random_traffic();
    sfrc_pkg::payload_t p;
    logic [15:0]        c;
    int unsigned        frame_bytes;
    int unsigned        frames;
    int unsigned        kind;
    int unsigned        n;
    int                 k;
    frame_bytes = 0;
    frames      = 0;
    while (frame_bytes < RandBytes) begin
      if (frames % 16 == 0) begin
        no_gaps  = ($urandom_range(0, 3) == 0);
        no_stall = ($urandom_range(0, 3) == 0);
      end
      frames++;
      for (k = 0; k < sfrc_pkg::PayloadLen; k++) p[k] = pick_byte();
      c    = frame_checksum(p);
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        send_frame(p, c);
        frame_bytes += 12;
      end else if (kind < 82) begin
        c = c ^ (16'h0001 << $urandom_range(0, 15));
        send_frame(p, c);
        frame_bytes += 12;
      end else if (kind < 90) begin
        // cut short; the next frame's sync bytes may get swallowed as payload or check bytes
        n = $urandom_range(0, 9);
        send_byte(sfrc_pkg::SyncByte);
        send_byte(sfrc_pkg::SyncByte);
        for (k = 0; k < n; k++) send_byte((k < sfrc_pkg::PayloadLen) ? p[k] : c[15:8]);
        frame_bytes += 2 + n;
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) send_byte(pick_byte());
      end
    end
    no_gaps  = 1'b0;
    no_stall = 1'b0;
  endtask

  initial begin
    wait (cycles >= CycleLimit);
    $display("sync_frame_receiver_checksum: mismatch");
    $finish;
  end

  initial begin
    rx_phase   = sfrc_pkg::PH_HUNT0;
    pay_idx    = '0;
    rx_payload = '0;
    chk_hi     = 8'h00;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_sync_hunt();
    test_sum_extremes();
    test_bad_checksum();
    test_output_backpressure();
    test_random_traffic();

    in_valid <= 1'b0;
    no_stall = 1'b1;
    while (good_frame_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("sync_frame_receiver_checksum: match");
    end else begin
      $display("sync_frame_receiver_checksum: mismatch");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/sfrc_pkg.sv
src/sfrc_framer.sv
src/sync_frame_receiver_checksum.sv
tb/tb_sync_frame_receiver_checksum.sv
